### sv/eopt_pkg.sv
// Package for the expert owner placement table.
// Holds sizes, action and status codes, controller states and the
// command and status structs shared by the controller and the datapath.
package eopt_pkg;

  localparam int MAX_EXPERTS = 256;
  localparam int MAX_OWNERS  = 64;

  localparam int EXP_W   = $clog2(MAX_EXPERTS);
  localparam int OWN_W   = $clog2(MAX_OWNERS);
  localparam int CNT_W   = EXP_W + 1;
  localparam int OCFG_W  = OWN_W + 1;

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_QEXP   = 2'd2;
  localparam logic [1:0] ACT_QOWN   = 2'd3;

  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_OWNER_RANGE    = 3'd1;
  localparam logic [2:0] ST_EXPERT_RANGE   = 3'd2;
  localparam logic [2:0] ST_COUNT_MISMATCH = 3'd3;
  localparam logic [2:0] ST_EMPTY_OWNER    = 3'd4;
  localparam logic [2:0] ST_NOT_READY      = 3'd5;
  localparam logic [2:0] ST_FULL           = 3'd6;

  localparam logic REG_OWNERS  = 1'b0;
  localparam logic REG_EXPERTS = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN
  } eopt_state_t;

  typedef struct packed {
    logic capture;
    logic commit;
    logic scan_clear;
    logic scan_step;
    logic scan_emit;
  } eopt_cmd_t;

  typedef struct packed {
    logic out_free;
    logic start_scan;
    logic scan_empty;
    logic scan_last;
  } eopt_sts_t;

endpackage

### sv/eopt_if.sv
// Valid/ready channel interfaces for the placement table.
// Depends on eopt_pkg for the field widths.
interface eopt_in_if import eopt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       action;
  logic [OWN_W-1:0] owner_id;
  logic [EXP_W-1:0] expert_id;

  modport source (output valid, action, owner_id, expert_id, input ready);
  modport sink (input valid, action, owner_id, expert_id, output ready);
endinterface

interface eopt_out_if import eopt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       status;
  logic [OWN_W-1:0] owner_out;
  logic [EXP_W-1:0] local_index;
  logic [CNT_W-1:0] owner_total;

  modport source (output valid, status, owner_out, local_index, owner_total, input ready);
  modport sink (input valid, status, owner_out, local_index, owner_total, output ready);
endinterface

### sv/eopt_ctrl.sv
// Controller state machine of the placement table.
// Sequences capture, commit and the finish scan; depends on eopt_pkg.
module eopt_ctrl import eopt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  eopt_sts_t sts,
  output eopt_cmd_t cmd
);

  eopt_state_t state, state_next;
  logic        scan_stop;

  assign scan_stop = sts.scan_empty || sts.scan_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (sts.start_scan) state_next = S_SCAN;
        else if (sts.out_free) state_next = S_IDLE;
      end
      S_SCAN: begin
        if (scan_stop && sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_EXEC: begin
        cmd.scan_clear = sts.start_scan;
        cmd.commit     = !sts.start_scan && sts.out_free;
      end
      S_SCAN: begin
        cmd.scan_step = !scan_stop;
        cmd.scan_emit = scan_stop && sts.out_free;
      end
      default: ;
    endcase
  end

  a_capture_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> state == S_EXEC)
    else $error("capture not followed by execute");
  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit || cmd.scan_emit) |-> sts.out_free)
    else $error("result written while output register full");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    !(cmd.commit && cmd.scan_emit))
    else $error("two results in one cycle");
  a_scan_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && !scan_stop) |=> state == S_SCAN)
    else $error("scan left before its end");

endmodule

### sv/eopt_dp.sv
// Datapath of the placement table: configuration registers, expert table
// memory, owner count memory with valid bits, scan index and output register.
// Depends on eopt_pkg; driven by eopt_ctrl through eopt_cmd_t.
module eopt_dp import eopt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  eopt_cmd_t         cmd,
  output eopt_sts_t         sts,
  input  logic [1:0]        action,
  input  logic [OWN_W-1:0]  owner_id,
  input  logic [EXP_W-1:0]  expert_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        status,
  output logic [OWN_W-1:0]  owner_out,
  output logic [EXP_W-1:0]  local_index,
  output logic [CNT_W-1:0]  owner_total,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata
);

  logic [OCFG_W-1:0] owners_in_use;
  logic [CNT_W-1:0]  experts_in_use;
  logic [CNT_W-1:0]  loaded_experts;
  logic              table_ready;

  logic [OWN_W+EXP_W-1:0] tbl_mem [MAX_EXPERTS];
  logic [CNT_W-1:0]       cnt_mem [MAX_OWNERS];
  logic [MAX_OWNERS-1:0]  cnt_vld;

  logic [1:0]             act_q;
  logic [OWN_W-1:0]       own_q;
  logic [EXP_W-1:0]       exp_q;
  logic [OWN_W+EXP_W-1:0] tbl_rd;
  logic [CNT_W-1:0]       cnt_rd;
  logic                   cnt_rv;
  logic [OWN_W-1:0]       scan_idx;

  logic             cfg_wr;
  logic [CNT_W-1:0] cnt_eff;
  logic             own_bad;
  logic             load_ok;
  logic [2:0]       res_status;
  logic [OWN_W-1:0] res_owner;
  logic [EXP_W-1:0] res_local;
  logic [CNT_W-1:0] res_total;

  assign cfg_wr  = psel && penable && pwrite;
  assign prdata  = (paddr[2] == REG_EXPERTS) ? {{(32-CNT_W){1'b0}}, experts_in_use}
                                             : {{(32-OCFG_W){1'b0}}, owners_in_use};
  assign cnt_eff = cnt_rv ? cnt_rd : '0;
  assign own_bad = {1'b0, own_q} >= owners_in_use;

  always_comb begin
    res_status = ST_OK;
    res_owner  = '0;
    res_local  = '0;
    res_total  = '0;
    load_ok    = 1'b0;
    case (act_q)
      ACT_LOAD: begin
        if (loaded_experts >= experts_in_use || loaded_experts >= CNT_W'(MAX_EXPERTS)) begin
          res_status = ST_FULL;
        end else if (own_bad) begin
          res_status = ST_OWNER_RANGE;
        end else begin
          load_ok   = 1'b1;
          res_local = cnt_eff[EXP_W-1:0];
        end
      end
      ACT_FINISH: begin
        if (experts_in_use == '0 || experts_in_use > CNT_W'(MAX_EXPERTS)) begin
          res_status = ST_EXPERT_RANGE;
        end else if (owners_in_use == '0 || owners_in_use > OCFG_W'(MAX_OWNERS) ||
                     CNT_W'(owners_in_use) > experts_in_use) begin
          res_status = ST_OWNER_RANGE;
        end else if (loaded_experts != experts_in_use) begin
          res_status = ST_COUNT_MISMATCH;
        end
      end
      ACT_QEXP: begin
        if (!table_ready) begin
          res_status = ST_NOT_READY;
        end else if ({1'b0, exp_q} >= experts_in_use) begin
          res_status = ST_EXPERT_RANGE;
        end else begin
          res_owner = tbl_rd[OWN_W+EXP_W-1:EXP_W];
          res_local = tbl_rd[EXP_W-1:0];
        end
      end
      default: begin
        if (!table_ready) begin
          res_status = ST_NOT_READY;
        end else if (own_bad) begin
          res_status = ST_OWNER_RANGE;
        end else begin
          res_total = cnt_eff;
        end
      end
    endcase
  end

  assign sts.out_free   = !out_valid || out_ready;
  assign sts.start_scan = (act_q == ACT_FINISH) && (res_status == ST_OK);
  assign sts.scan_empty = !cnt_vld[scan_idx];
  assign sts.scan_last  = {1'b0, scan_idx} == (owners_in_use - OCFG_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_q  <= action;
      own_q  <= owner_id;
      exp_q  <= expert_id;
      tbl_rd <= tbl_mem[expert_id];
      cnt_rd <= cnt_mem[owner_id];
      cnt_rv <= cnt_vld[owner_id];
    end
    if (cmd.commit && load_ok) begin
      tbl_mem[loaded_experts[EXP_W-1:0]] <= {own_q, cnt_eff[EXP_W-1:0]};
      cnt_mem[own_q] <= cnt_eff + CNT_W'(1);
    end
    if (cmd.scan_clear) begin
      scan_idx <= '0;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + OWN_W'(1);
    end
    if (cmd.commit) begin
      status      <= res_status;
      owner_out   <= res_owner;
      local_index <= res_local;
      owner_total <= res_total;
    end else if (cmd.scan_emit) begin
      status      <= sts.scan_empty ? ST_EMPTY_OWNER : ST_OK;
      owner_out   <= '0;
      local_index <= '0;
      owner_total <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      owners_in_use  <= OCFG_W'(1);
      experts_in_use <= CNT_W'(1);
      loaded_experts <= '0;
      table_ready    <= 1'b0;
      cnt_vld        <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == REG_EXPERTS) experts_in_use <= pwdata[CNT_W-1:0];
        else owners_in_use <= pwdata[OCFG_W-1:0];
        loaded_experts <= '0;
        table_ready    <= 1'b0;
        cnt_vld        <= '0;
      end else begin
        if (cmd.commit && load_ok) begin
          loaded_experts <= loaded_experts + CNT_W'(1);
          cnt_vld[own_q] <= 1'b1;
        end
        if (cmd.commit && act_q == ACT_FINISH) table_ready <= 1'b0;
        if (cmd.scan_emit) table_ready <= !sts.scan_empty;
      end
      if (cmd.commit || cmd.scan_emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  a_load_counts: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && load_ok && !cfg_wr) |=> loaded_experts == $past(loaded_experts) + CNT_W'(1))
    else $error("load did not advance the expert count");
  a_ready_by_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(table_ready) |-> $past(cmd.scan_emit))
    else $error("table became ready without a finish scan");
  a_full_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !(cmd.commit || cmd.scan_emit))
    else $error("output register overwritten");

endmodule

### sv/expert_owner_placement_table.sv
// Expert owner placement table, top level. Depends on eopt_pkg, eopt_if,
// eopt_ctrl and eopt_dp.
// A finish that passes its register and count checks scans the owners up to the
// first empty one or the last in use (at most 64 owners). A new item is taken
// only once the result of the last one has entered the output register.
// Reset (rst, synchronous): registers return to one owner and one expert,
// all owner count valid bits and the load count clear at once, and the table is not ready.
module expert_owner_placement_table import eopt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  eopt_in_if.sink     in_ch,
  eopt_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  eopt_cmd_t cmd;
  eopt_sts_t sts;

  assign pready = 1'b1;

  eopt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  eopt_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .action      (in_ch.action),
    .owner_id    (in_ch.owner_id),
    .expert_id   (in_ch.expert_id),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .status      (out_ch.status),
    .owner_out   (out_ch.owner_out),
    .local_index (out_ch.local_index),
    .owner_total (out_ch.owner_total),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata)
  );

endmodule
